// File: hdl/gmf_pkg.sv
`timescale 1ns / 1ps

package gmf_pkg;

	localparam int CFG_W         = 11;
	localparam int PIX_W         = 8;
	localparam int COORD_W       = 10;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int MIN_DIM       = 3;
	localparam int ACC_W         = 24;
	localparam int CFG_INDEX_W   = 1;

	localparam logic [15:0] W_RED   = 16'd19661;
	localparam logic [15:0] W_GREEN = 16'd38666;
	localparam logic [15:0] W_BLUE  = 16'd7209;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
	} pix_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
		logic               frame_end;
	} meta_t;

	typedef struct packed {
		pix_t               median_gray;
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
		logic               frame_end;
	} pix_out_t;

	// Window indexed as [row][column]; column 2 holds the newest pixel.
	typedef pix_t [2:0][2:0] win_t;

	typedef struct packed {
		pix_t lo;
		pix_t md;
		pix_t hi;
	} col3_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} lb_ctrl_t;

	function automatic pix_t gray_of(pix_in_t p);
		logic [ACC_W-1:0] acc;
		acc = ACC_W'(W_RED) * ACC_W'(p.red) + ACC_W'(W_GREEN) * ACC_W'(p.green)
			+ ACC_W'(W_BLUE) * ACC_W'(p.blue);
		return acc[ACC_W-1:ACC_W-PIX_W];
	endfunction

	function automatic pix_t max2(pix_t a, pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t min2(pix_t a, pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic col3_t sort3(pix_t a, pix_t b, pix_t c);
		col3_t s;
		s.lo = min2(min2(a, b), c);
		s.hi = max2(max2(a, b), c);
		s.md = med3(a, b, c);
		return s;
	endfunction

endpackage

// File: hdl/gmf_line_window.sv
`timescale 1ns / 1ps

module gmf_line_window #(
	parameter int MAX_WIDTH = gmf_pkg::MAX_WIDTH_DEF,
	parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gmf_pkg::lb_ctrl_t ctrl,
	input  logic [AW-1:0]    rd_addr,
	input  logic [AW-1:0]    wr_addr,
	input  gmf_pkg::pix_t    gray,
	output gmf_pkg::win_t    window
);

	gmf_pkg::pix_t upper_line_q [MAX_WIDTH];
	gmf_pkg::pix_t middle_line_q [MAX_WIDTH];
	gmf_pkg::pix_t rd_up_q;
	gmf_pkg::pix_t rd_mid_q;
	gmf_pkg::win_t window_q;

	// The read for a pixel is issued on its transfer; its write follows one
	// advance later, and consecutive pixels never share a column address.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			upper_line_q[wr_addr]  <= rd_mid_q;
			middle_line_q[wr_addr] <= gray;
		end
		if (ctrl.rd_en) begin
			rd_up_q  <= upper_line_q[rd_addr];
			rd_mid_q <= middle_line_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (ctrl.wr_en) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r][0] <= window_q[r][1];
				window_q[r][1] <= window_q[r][2];
			end
			window_q[0][2] <= rd_up_q;
			window_q[1][2] <= rd_mid_q;
			window_q[2][2] <= gray;
		end
	end

	assign window = window_q;

endmodule

// File: hdl/gmf_median.sv
`timescale 1ns / 1ps

module gmf_median (
	input  logic          clk,
	input  logic          en,
	input  gmf_pkg::win_t window,
	output gmf_pkg::pix_t median
);

	gmf_pkg::col3_t [2:0] cols_s3;
	gmf_pkg::pix_t        lo_max;
	gmf_pkg::pix_t        md_med;
	gmf_pkg::pix_t        hi_min;

	// Each column is sorted first; the median of nine is then the median of
	// the largest low, the middle median and the smallest high.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				cols_s3[c] <= gmf_pkg::sort3(window[0][c], window[1][c], window[2][c]);
			end
		end
	end

	always_comb begin
		lo_max = gmf_pkg::max2(gmf_pkg::max2(cols_s3[0].lo, cols_s3[1].lo), cols_s3[2].lo);
		md_med = gmf_pkg::med3(cols_s3[0].md, cols_s3[1].md, cols_s3[2].md);
		hi_min = gmf_pkg::min2(gmf_pkg::min2(cols_s3[0].hi, cols_s3[1].hi), cols_s3[2].hi);
		median = gmf_pkg::med3(lo_max, md_med, hi_min);
	end

endmodule

// File: hdl/gray_median_filter_3x3_core.sv
`timescale 1ns / 1ps
// Path: the input stage, window, column sort and output register lie between the transfer of
// the pixel that completes a window and its result. Throughput: one pixel per cycle unless the
// output stalls, set by one read and one write of each line store per pixel.
// Reset clears counters, window, valid flags and restores width 640 and height 480;
// line stores are not cleared and need no clearing pass.

module gray_median_filter_3x3_core #(
	parameter int MAX_WIDTH = gmf_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  gmf_pkg::pix_in_t                    pixel,
	output logic                                result_valid,
	input  logic                                result_ready,
	output gmf_pkg::pix_out_t                   result,
	input  logic                                cfg_we,
	input  logic [gmf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [gmf_pkg::CFG_W-1:0]           cfg_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LW = $clog2(MAX_WIDTH + 1);
	localparam int CW = (gmf_pkg::CFG_W > LW) ? gmf_pkg::CFG_W : LW;
	localparam int HW = gmf_pkg::CFG_W;

	logic [gmf_pkg::CFG_W-1:0]   width_q;
	logic [gmf_pkg::CFG_W-1:0]   height_q;
	logic [gmf_pkg::COORD_W-1:0] col_q;
	logic [gmf_pkg::COORD_W-1:0] row_q;
	logic [AW-1:0]               addr_q;

	logic [CW-1:0] width_ext;
	logic [CW-1:0] width_use;
	logic [HW-1:0] height_use;
	logic          last_col;
	logic          last_row;
	logic          col_wrap;
	logic          emit;
	logic          accept;
	logic          en;

	logic             v_s1, emit_s1, v_s2, v_s3;
	gmf_pkg::pix_in_t pix_s1;
	logic [AW-1:0]    addr_s1;
	gmf_pkg::meta_t   meta_s1, meta_s2, meta_s3;
	gmf_pkg::pix_t    gray_s1;
	gmf_pkg::pix_t    median;
	gmf_pkg::lb_ctrl_t lb_ctrl;
	gmf_pkg::win_t    window;

	logic              result_valid_q;
	gmf_pkg::pix_out_t result_q;

	assign en          = !result_valid_q || result_ready;
	assign pixel_ready = en;
	assign accept      = pixel_valid && en;

	always_comb begin
		width_ext = CW'(width_q);
		if (width_ext < CW'(gmf_pkg::MIN_DIM)) begin
			width_use = CW'(gmf_pkg::MIN_DIM);
		end else if (width_ext > CW'(MAX_WIDTH)) begin
			width_use = CW'(MAX_WIDTH);
		end else begin
			width_use = width_ext;
		end
		if (height_q < HW'(gmf_pkg::MIN_DIM)) begin
			height_use = HW'(gmf_pkg::MIN_DIM);
		end else if (height_q > HW'(gmf_pkg::MAX_HEIGHT)) begin
			height_use = HW'(gmf_pkg::MAX_HEIGHT);
		end else begin
			height_use = height_q;
		end
		last_col = (CW'(col_q) + CW'(1)) >= width_use;
		last_row = (HW'(row_q) + HW'(1)) >= height_use;
		col_wrap = last_col || (col_q == '1);
		emit     = (row_q >= gmf_pkg::COORD_W'(2)) && (col_q >= gmf_pkg::COORD_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gmf_pkg::CFG_W'(640);
			height_q <= gmf_pkg::CFG_W'(480);
			col_q    <= '0;
			row_q    <= '0;
			addr_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gmf_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
					gmf_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				endcase
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + gmf_pkg::COORD_W'(1);
				end else begin
					col_q <= col_q + gmf_pkg::COORD_W'(1);
				end
				if (col_wrap || (addr_q == AW'(MAX_WIDTH - 1))) begin
					addr_q <= '0;
				end else begin
					addr_q <= addr_q + AW'(1);
				end
			end
			if (en) begin
				v_s1 <= accept;
				v_s2 <= v_s1 && emit_s1;
				v_s3 <= v_s2;
				result_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1             <= pixel;
			addr_s1            <= addr_q;
			emit_s1            <= emit;
			meta_s1.center_row <= row_q - gmf_pkg::COORD_W'(1);
			meta_s1.center_col <= col_q - gmf_pkg::COORD_W'(1);
			meta_s1.frame_end  <= last_col && last_row;
		end
		if (en) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			result_q.median_gray <= median;
			result_q.center_row  <= meta_s3.center_row;
			result_q.center_col  <= meta_s3.center_col;
			result_q.frame_end   <= meta_s3.frame_end;
		end
	end

	assign gray_s1       = gmf_pkg::gray_of(pix_s1);
	assign lb_ctrl.rd_en = accept;
	assign lb_ctrl.wr_en = en && v_s1;

	gmf_line_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_line_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lb_ctrl),
		.rd_addr (addr_q),
		.wr_addr (addr_s1),
		.gray    (gray_s1),
		.window  (window)
	);

	gmf_median u_median (
		.clk    (clk),
		.en     (en),
		.window (window),
		.median (median)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: hdl/gmf_checker.sv
`timescale 1ns / 1ps

module gmf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pixel_ready,
	input logic              result_valid,
	input logic              result_ready,
	input gmf_pkg::pix_out_t result
);

	// A stalled result stays offered with the same payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed or was dropped");

	// Input is taken exactly when the output side can move.
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_ready == (!result_valid || result_ready))
		else $error("input ready does not follow output stall");

	// Results are interior centers only.
	a_interior_center: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.center_row != '0) && (result.center_col != '0))
		else $error("result on a border position");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result offered during reset");

endmodule

bind gray_median_filter_3x3_core gmf_checker u_gmf_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	gmf_pkg::pix_in_t pixel = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	gmf_pkg::pix_out_t result;
	logic cfg_we = 1'b0;
	logic [gmf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [gmf_pkg::CFG_W-1:0] cfg_data = '0;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int pixels_sent = 0;
	int medians_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;

	// Shadow copy of the filter state, advanced on every pixel transfer.
	logic [gmf_pkg::CFG_W-1:0] width_reg = 11'd640;
	logic [gmf_pkg::CFG_W-1:0] height_reg = 11'd480;
	gmf_pkg::pix_t upper_row [gmf_pkg::MAX_WIDTH_DEF];
	gmf_pkg::pix_t middle_row [gmf_pkg::MAX_WIDTH_DEF];
	gmf_pkg::pix_t win_taps [3][3] = '{default: '0};
	logic [gmf_pkg::COORD_W-1:0] col_pos = '0;
	logic [gmf_pkg::COORD_W-1:0] row_pos = '0;
	gmf_pkg::pix_out_t window_medians [$];
	gmf_pkg::pix_out_t want;

	gray_median_filter_3x3_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic int clamp_dim(input int v, input int hi);
		if (v < gmf_pkg::MIN_DIM)
			return gmf_pkg::MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void set_idling(input int gap_pct, input int stall_pct);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
	endfunction

	function automatic void filter_pixel(input gmf_pkg::pix_in_t p);
		int w, h, acc, below, not_above;
		gmf_pkg::pix_t gray, up, mid, med;
		logic last_col, last_row;
		gmf_pkg::pix_out_t r;
		w = clamp_dim(int'(width_reg), gmf_pkg::MAX_WIDTH_DEF);
		h = clamp_dim(int'(height_reg), gmf_pkg::MAX_HEIGHT);
		acc = int'(gmf_pkg::W_RED) * int'(p.red) + int'(gmf_pkg::W_GREEN) * int'(p.green)
			+ int'(gmf_pkg::W_BLUE) * int'(p.blue);
		gray = gmf_pkg::pix_t'(acc >> 16);
		up = upper_row[col_pos];
		mid = middle_row[col_pos];
		last_col = (int'(col_pos) + 1 >= w);
		last_row = (int'(row_pos) + 1 >= h);
		for (int m = 0; m < 3; m++) begin
			win_taps[m][0] = win_taps[m][1];
			win_taps[m][1] = win_taps[m][2];
		end
		win_taps[0][2] = up;
		win_taps[1][2] = mid;
		win_taps[2][2] = gray;
		upper_row[col_pos] = mid;
		middle_row[col_pos] = gray;
		if (row_pos >= 2 && col_pos >= 2) begin
			// The median is the tap with at most four smaller and at least five not larger.
			med = '0;
			for (int i = 0; i < 9; i++) begin
				below = 0;
				not_above = 0;
				for (int j = 0; j < 9; j++) begin
					if (win_taps[j / 3][j % 3] < win_taps[i / 3][i % 3])
						below++;
					if (win_taps[j / 3][j % 3] <= win_taps[i / 3][i % 3])
						not_above++;
				end
				if (below <= 4 && not_above >= 5)
					med = win_taps[i / 3][i % 3];
			end
			r.median_gray = med;
			r.center_row = row_pos - gmf_pkg::COORD_W'(1);
			r.center_col = col_pos - gmf_pkg::COORD_W'(1);
			r.frame_end = last_col && last_row;
			window_medians.push_back(r);
		end
		if (last_col) begin
			col_pos = '0;
			row_pos = last_row ? '0 : row_pos + gmf_pkg::COORD_W'(1);
		end else begin
			col_pos = col_pos + gmf_pkg::COORD_W'(1);
		end
	endfunction

	function automatic gmf_pkg::pix_in_t make_pixel(input int style);
		gmf_pkg::pix_in_t p;
		int lvl;
		p = 24'($urandom);
		if (style == 1) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(2))
					0: p[k*8 +: 8] = 8'h00;
					1: p[k*8 +: 8] = 8'hFF;
					default: ;
				endcase
			end
		end else if (style == 2) begin
			lvl = int'($urandom_range(6)) * 40;
			p.red = 8'(lvl + int'($urandom_range(3)));
			p.green = 8'(lvl + int'($urandom_range(3)));
			p.blue = 8'(lvl + int'($urandom_range(3)));
		end
		return p;
	endfunction

	task automatic check_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", field, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (window_medians.size() == 0) begin
				$error("result transfer with no median pending: row %0d col %0d",
					result.center_row, result.center_col);
				mismatches++;
			end else begin
				want = window_medians.pop_front();
				check_field("median_gray", want.median_gray, result.median_gray);
				check_field("center_row", want.center_row, result.center_row);
				check_field("center_col", want.center_col, result.center_col);
				check_field("frame_end", want.frame_end, result.frame_end);
				medians_checked++;
			end
		end
	end

	task automatic send_pixel(input gmf_pkg::pix_in_t p);
		while ($urandom_range(99) < send_gap_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
		filter_pixel(p);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (window_medians.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [gmf_pkg::CFG_INDEX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= gmf_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == gmf_pkg::REG_FRAME_WIDTH)
			width_reg = gmf_pkg::CFG_W'(value);
		else
			height_reg = gmf_pkg::CFG_W'(value);
		@(negedge clk);
	endtask

	task automatic send_frame(input int w_val, input int h_val, input int style);
		drain();
		write_reg(gmf_pkg::REG_FRAME_WIDTH, w_val);
		write_reg(gmf_pkg::REG_FRAME_HEIGHT, h_val);
		repeat (clamp_dim(w_val, gmf_pkg::MAX_WIDTH_DEF) * clamp_dim(h_val, gmf_pkg::MAX_HEIGHT))
			send_pixel(make_pixel(style));
	endtask

	// Wraps a row at the reset width, then shrinks width and height in the middle
	// of a frame while each count is past its new limit.
	task automatic test_live_resize();
		set_idling(0, 0);
		repeat (640 + 30) send_pixel(make_pixel(0));
		drain();
		write_reg(gmf_pkg::REG_FRAME_WIDTH, 20);
		repeat (1 + 2 * 20 + 5) send_pixel(make_pixel(1));
		drain();
		write_reg(gmf_pkg::REG_FRAME_HEIGHT, 3);
		repeat (15) send_pixel(make_pixel(0));
	endtask

	task automatic test_corner_pixels();
		logic [23:0] tiny [9] = '{24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00,
			24'h0000FF, 24'h006400, 24'h00C800, 24'h640000, 24'h000064};
		logic [23:0] square [16] = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h808080,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010101, 24'hFEFEFE, 24'h00C800,
			24'h00C800, 24'h7F7F7F, 24'h000000, 24'hFFFFFF, 24'h123456, 24'hABCDEF};
		set_idling(0, 0);
		drain();
		write_reg(gmf_pkg::REG_FRAME_WIDTH, 0);
		write_reg(gmf_pkg::REG_FRAME_HEIGHT, 2);
		foreach (tiny[i])
			send_pixel(gmf_pkg::pix_in_t'(tiny[i]));
		drain();
		write_reg(gmf_pkg::REG_FRAME_WIDTH, 4);
		write_reg(gmf_pkg::REG_FRAME_HEIGHT, 4);
		foreach (square[i])
			send_pixel(gmf_pkg::pix_in_t'(square[i]));
	endtask

	task automatic test_random_frames();
		int gap_pct [4] = '{0, 47, 0, 34};
		int stall_pct [4] = '{0, 0, 47, 34};
		int stop_at, w_val, h_val;
		for (int ph = 0; ph < 4; ph++) begin
			set_idling(gap_pct[ph], stall_pct[ph]);
			stop_at = pixels_sent + 110;
			while (pixels_sent < stop_at) begin
				case ($urandom_range(9))
					0: w_val = $urandom_range(2);
					1: w_val = $urandom_range(40, 13);
					default: w_val = $urandom_range(12, 3);
				endcase
				h_val = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
				send_frame(w_val, h_val, $urandom_range(2));
			end
		end
	endtask

	task automatic test_tall_frame();
		set_idling(34, 34);
		send_frame(3, 40, 1);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_live_resize();
		test_corner_pixels();
		test_random_frames();
		test_tall_frame();
		drain();
		$display("Sent %0d pixels and checked %0d medians with their coordinates.",
			pixels_sent, medians_checked);
		$display("Covered the reset width, live resizing, clamped sizes and stalls on both sides.");
		if (mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
